### rtl/core/pvsl_pkg.sv
`timescale 1ns / 1ps

package pvsl_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CFG_W     = 31;
    localparam int PERIOD_W  = 17;
    localparam int NEAR_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 3'd5;

    localparam logic [CFG_W-1:0]    RST_MAX_ACCEL      = 31'd65536;
    localparam logic [CFG_W-1:0]    RST_MAX_SPEED      = 31'd65536;
    localparam logic [CFG_W-1:0]    RST_TRACK_GAIN     = 31'd65536;
    localparam logic [CFG_W-1:0]    RST_DEAD_ZONE      = 31'd0;
    localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD    = 17'd655;
    localparam logic [NEAR_W-1:0]   RST_NEAR_THRESHOLD = 16'd66;

    localparam int RAD_W       = 64;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int MUL_CHUNK   = 16;
    localparam int MUL_STEPS   = RAD_W / MUL_CHUNK;
    localparam int MCNT_W      = $clog2(MUL_STEPS);
    localparam int ACC_W       = CFG_W + RAD_W;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [CFG_W-1:0]    max_accel;
        logic [CFG_W-1:0]    max_speed;
        logic [CFG_W-1:0]    track_gain;
        logic [CFG_W-1:0]    dead_zone;
        logic [PERIOD_W-1:0] step_period;
        logic [NEAR_W-1:0]   near_threshold;
    } pvsl_cfg_t;

    typedef enum logic {
        KIND_PROFILE = 1'b0,
        KIND_TARGET  = 1'b1
    } pvsl_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_SCALE,
        ST_MUL_ACCEL,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_SIGN,
        ST_SLEW,
        ST_STEP,
        ST_CLAMP
    } pvsl_state_t;

endpackage

### rtl/core/pvsl_if.sv
`timescale 1ns / 1ps

interface pvsl_item_if import pvsl_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, req_type, value, input ready);
    modport sink   (input valid, req_type, value, output ready);
endinterface

interface pvsl_result_if import pvsl_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] velocity_cmd;

    modport source (output valid, velocity_cmd, input ready);
    modport sink   (input valid, velocity_cmd, output ready);
endinterface

interface pvsl_cfg_if import pvsl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/pvsl_front.sv
`timescale 1ns / 1ps

module pvsl_front import pvsl_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pvsl_cfg_t                    regs,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         item_req_type,
    input  logic signed [DATA_WIDTH-1:0] item_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [DATA_WIDTH+1:0]        out_data
);

    localparam int RW = (DATA_WIDTH > CFG_W) ? DATA_WIDTH : CFG_W;

    logic                  valid_reg, valid_next;
    pvsl_kind_t            kind_reg, kind_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;

    logic                  neg;
    logic [DATA_WIDTH-1:0] mag;
    logic [RW-1:0]         mag_w;
    logic [RW-1:0]         dz_w;
    logic [RW-1:0]         red_w;
    logic [DATA_WIDTH-1:0] red;
    logic                  accept;

    assign item_ready = !valid_reg || out_ready;
    assign accept     = item_valid && item_ready;
    assign out_valid  = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            kind_next  = pvsl_kind_t'(item_req_type);
            value_next = item_value;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // shrink the error magnitude by the dead zone, floor at zero
    always_comb
    begin
        neg   = value_reg[DATA_WIDTH-1];
        mag   = neg ? (~value_reg + 1'b1) : value_reg;
        mag_w = RW'(mag);
        dz_w  = RW'(regs.dead_zone);
        red_w = (mag_w > dz_w) ? (mag_w - dz_w) : '0;
        red   = red_w[DATA_WIDTH-1:0];
    end

    always_comb
    begin
        if (kind_reg == KIND_TARGET)
        begin
            out_data = {KIND_TARGET, 1'b0, value_reg};
        end
        else if (red < DATA_WIDTH'(regs.near_threshold))
        begin
            out_data = {KIND_TARGET, 1'b0, {DATA_WIDTH{1'b0}}};
        end
        else
        begin
            out_data = {KIND_PROFILE, neg, red};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
    end

endmodule

### rtl/core/pvsl_queue.sv
`timescale 1ns / 1ps

module pvsl_queue import pvsl_pkg::*; #(
    parameter int WIDTH = DATA_WIDTH_DEF + 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### rtl/core/pvsl_sqrt.sv
`timescale 1ns / 1ps

module pvsl_sqrt import pvsl_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  x,
    output logic              busy,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int ITER_W = $clog2(ROOT_W);
    localparam int SH_W   = ROOT_W + 3;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [RAD_W-1:0]  xs_reg, xs_next;
    logic [ROOT_W:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic [SH_W-1:0]   rem_sh;
    logic [SH_W-1:0]   trial;
    logic [SH_W-1:0]   diff;
    logic              fits;

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

    // one result bit per cycle, restoring
    always_comb
    begin
        rem_sh = {rem_reg, xs_reg[RAD_W-1 -: 2]};
        trial  = SH_W'({root_reg, 2'b01});
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        xs_next   = xs_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            xs_next   = x;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            xs_next   = xs_reg << 2;
            rem_next  = fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
            root_next = {root_reg[ROOT_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == ITER_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg   <= xs_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

### rtl/core/pvsl_back.sv
`timescale 1ns / 1ps

module pvsl_back import pvsl_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pvsl_cfg_t                    regs,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [DATA_WIDTH+1:0]        q_data,
    output logic                         sqrt_start,
    output logic [RAD_W-1:0]             sqrt_x,
    input  logic                         sqrt_done,
    input  logic [ROOT_W-1:0]            sqrt_root,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic signed [DATA_WIDTH-1:0] res_data
);

    localparam int DW     = DATA_WIDTH;
    localparam int DIFF_W = DW + 1;
    localparam int PROD_W = CFG_W + PERIOD_W;
    localparam int STEP_W = PROD_W - FRAC_BITS;
    localparam int NXT_W  = ((DW > STEP_W + 1) ? DW : STEP_W + 1) + 1;
    localparam int CMP_W  = (DIFF_W > STEP_W) ? DIFF_W : STEP_W;
    localparam int LIM_W  = (DW > CFG_W) ? DW : CFG_W;
    localparam int RC_W   = (DW > ROOT_W) ? DW : ROOT_W;
    localparam int PP_W   = CFG_W + MUL_CHUNK;
    localparam logic [DW-1:0] DMAX = {1'b0, {(DW - 1){1'b1}}};

    pvsl_state_t             state_reg, state_next;
    logic                    neg_reg, neg_next;
    logic [CFG_W-1:0]        opa_reg, opa_next;
    logic [RAD_W-1:0]        opb_reg, opb_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [MCNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [DW-1:0]    target_reg, target_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [NXT_W-1:0] nxt_reg, nxt_next;
    logic signed [DW-1:0]    cur_reg, cur_next;
    logic                    res_valid_reg, res_valid_next;
    logic signed [DW-1:0]    res_data_reg, res_data_next;
    logic [STEP_W-1:0]       step_reg;

    logic                    load_item;
    logic                    mul_run;
    logic                    deliver;
    logic                    mul_last;
    pvsl_kind_t              q_kind;
    logic [PP_W-1:0]         pp;
    logic [RAD_W-1:0]        acc_sat;
    logic [PROD_W-1:0]       step_prod;
    logic [RC_W-1:0]         root_w;
    logic signed [DW-1:0]    mag_t;
    logic [DIFF_W-1:0]       gap_mag;
    logic                    snap;
    logic signed [NXT_W-1:0] cur_x;
    logic signed [NXT_W-1:0] step_x;
    logic [LIM_W-1:0]        lim_w;
    logic signed [DW-1:0]    lim;
    logic signed [NXT_W-1:0] lim_x;
    logic signed [DW-1:0]    clamped;

    assign q_kind    = pvsl_kind_t'(q_data[DW+1]);
    assign mul_last  = (cnt_reg == MCNT_W'(MUL_STEPS - 1));
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;
    assign acc_sat   = (acc_reg[ACC_W-1:RAD_W] != '0) ? '1 : acc_reg[RAD_W-1:0];
    assign sqrt_x    = acc_sat;
    assign step_prod = regs.max_accel * regs.step_period;
    assign pp        = opa_reg * opb_reg[RAD_W-1 -: MUL_CHUNK];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_kind == KIND_PROFILE) ? ST_MUL_GAIN : ST_SLEW;
                end
            end
            ST_MUL_GAIN:   state_next = mul_last ? ST_SCALE : ST_MUL_GAIN;
            ST_SCALE:      state_next = ST_MUL_ACCEL;
            ST_MUL_ACCEL:  state_next = mul_last ? ST_ROOT_START : ST_MUL_ACCEL;
            ST_ROOT_START: state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:  state_next = sqrt_done ? ST_SIGN : ST_ROOT_WAIT;
            ST_SIGN:       state_next = ST_SLEW;
            ST_SLEW:       state_next = ST_STEP;
            ST_STEP:       state_next = ST_CLAMP;
            ST_CLAMP:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready    = 1'b0;
        sqrt_start = 1'b0;
        mul_run    = 1'b0;
        deliver    = 1'b0;
        case (state_reg)
            ST_IDLE:       q_ready    = 1'b1;
            ST_MUL_GAIN:   mul_run    = 1'b1;
            ST_MUL_ACCEL:  mul_run    = 1'b1;
            ST_ROOT_START: sqrt_start = 1'b1;
            ST_CLAMP:      deliver    = !res_valid_reg || res_ready;
            default:       q_ready    = 1'b0;
        endcase
    end

    assign load_item = q_ready && q_valid;

    // root saturated to the data range, then signed
    always_comb
    begin
        root_w = RC_W'(sqrt_root);
        if (root_w > RC_W'(DMAX))
        begin
            root_w = RC_W'(DMAX);
        end
        mag_t = $signed(root_w[DW-1:0]);
    end

    always_comb
    begin
        gap_mag = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
        snap    = (gap_mag < DIFF_W'(regs.near_threshold))
               || (CMP_W'(gap_mag) < CMP_W'(step_reg))
               || (diff_reg == '0);
        cur_x   = NXT_W'(cur_reg);
        step_x  = $signed(NXT_W'(step_reg));
    end

    always_comb
    begin
        lim_w = LIM_W'(regs.max_speed);
        if (lim_w > LIM_W'(DMAX))
        begin
            lim_w = LIM_W'(DMAX);
        end
        lim   = $signed(lim_w[DW-1:0]);
        lim_x = NXT_W'(lim);
        if (nxt_reg > lim_x)
        begin
            clamped = lim;
        end
        else if (nxt_reg < -lim_x)
        begin
            clamped = -lim;
        end
        else
        begin
            clamped = nxt_reg[DW-1:0];
        end
    end

    always_comb
    begin
        neg_next       = neg_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        target_next    = target_reg;
        diff_next      = diff_reg;
        nxt_next       = nxt_reg;
        cur_next       = cur_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (load_item)
        begin
            neg_next    = q_data[DW];
            target_next = $signed(q_data[DW-1:0]);
            opa_next    = regs.track_gain;
            opb_next    = RAD_W'(q_data[DW-1:0]);
            acc_next    = '0;
            cnt_next    = '0;
        end
        if (mul_run)
        begin
            acc_next = (acc_reg << MUL_CHUNK) + ACC_W'(pp);
            opb_next = opb_reg << MUL_CHUNK;
            cnt_next = cnt_reg + 1'b1;
        end
        if (state_reg == ST_SCALE)
        begin
            opa_next = regs.max_accel;
            opb_next = acc_sat >> FRAC_BITS;
            acc_next = '0;
            cnt_next = '0;
        end
        if (state_reg == ST_SIGN)
        begin
            target_next = neg_reg ? -mag_t : mag_t;
        end
        if (state_reg == ST_SLEW)
        begin
            diff_next = DIFF_W'(target_reg) - DIFF_W'(cur_reg);
        end
        if (state_reg == ST_STEP)
        begin
            if (snap)
            begin
                nxt_next = NXT_W'(target_reg);
            end
            else if (!diff_reg[DIFF_W-1])
            begin
                nxt_next = cur_x + step_x;
            end
            else
            begin
                nxt_next = cur_x - step_x;
            end
        end
        if (deliver)
        begin
            cur_next       = clamped;
            res_data_next  = clamped;
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        target_reg   <= target_next;
        diff_reg     <= diff_next;
        nxt_reg      <= nxt_next;
        res_data_reg <= res_data_next;
        step_reg     <= step_prod[PROD_W-1:FRAC_BITS];
    end

endmodule

### rtl/core/position_to_velocity_slew_limiter.sv
`timescale 1ns / 1ps

// Turns a position error or a direct velocity target into a slew-limited,
// speed-clamped velocity command, one result per transfer on the item channel.
// A front stage takes items and applies the dead zone; a two-entry queue
// decouples it from the back end, which runs the square-root braking profile
// and the slew step. A velocity target goes straight to slew and clamp.
// A position error whose size less the dead zone reaches the near threshold
// first runs two chunked 31x64 multiplies and the square root at one result
// bit per cycle; a smaller one becomes a zero target. Registers are written
// on the cfg channel, which is always ready; write them only while idle.
module position_to_velocity_slew_limiter import pvsl_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    pvsl_item_if.sink      item,
    pvsl_result_if.source  result,
    pvsl_cfg_if.sink       cfg
);

    pvsl_cfg_t               cfg_reg, cfg_next;

    logic                    q_in_valid;
    logic                    q_in_ready;
    logic [DATA_WIDTH+1:0]   q_in_data;
    logic                    q_out_valid;
    logic                    q_out_ready;
    logic [DATA_WIDTH+1:0]   q_out_data;
    logic                    q_pop;

    logic                    sqrt_start;
    logic [RAD_W-1:0]        sqrt_x;
    logic                    sqrt_busy;
    logic                    sqrt_done;
    logic [ROOT_W-1:0]       sqrt_root;

    assign cfg.ready = 1'b1;
    assign q_pop     = q_out_valid && q_out_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_MAX_ACCEL:      cfg_next.max_accel      = cfg.data;
                REG_MAX_SPEED:      cfg_next.max_speed      = cfg.data;
                REG_TRACK_GAIN:     cfg_next.track_gain     = cfg.data;
                REG_DEAD_ZONE:      cfg_next.dead_zone      = cfg.data;
                REG_STEP_PERIOD:    cfg_next.step_period    = cfg.data[PERIOD_W-1:0];
                REG_NEAR_THRESHOLD: cfg_next.near_threshold = cfg.data[NEAR_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_accel      <= RST_MAX_ACCEL;
            cfg_reg.max_speed      <= RST_MAX_SPEED;
            cfg_reg.track_gain     <= RST_TRACK_GAIN;
            cfg_reg.dead_zone      <= RST_DEAD_ZONE;
            cfg_reg.step_period    <= RST_STEP_PERIOD;
            cfg_reg.near_threshold <= RST_NEAR_THRESHOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pvsl_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .regs          (cfg_reg),
        .item_valid    (item.valid),
        .item_ready    (item.ready),
        .item_req_type (item.req_type),
        .item_value    (item.value),
        .out_valid     (q_in_valid),
        .out_ready     (q_in_ready),
        .out_data      (q_in_data)
    );

    pvsl_queue #(
        .WIDTH (DATA_WIDTH + 2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    pvsl_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (sqrt_x),
        .busy  (sqrt_busy),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    pvsl_back #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (cfg_reg),
        .q_valid    (q_out_valid),
        .q_ready    (q_out_ready),
        .q_data     (q_out_data),
        .sqrt_start (sqrt_start),
        .sqrt_x     (sqrt_x),
        .sqrt_done  (sqrt_done),
        .sqrt_root  (sqrt_root),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .res_data   (result.velocity_cmd)
    );

`ifndef SYNTHESIS
    a_pop_not_during_root: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !sqrt_busy)
        else $error("queue popped while root in progress");

    a_root_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |=> sqrt_busy && !sqrt_done)
        else $error("root unit did not start");

    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop)
        else $error("back end took two items in a row");
`endif

endmodule
